FILE: rtl/mtc_pkg.sv
package mtc_pkg;

  localparam int unsigned MAX_MARKERS_DEF = 64;

  localparam int unsigned CNT_W   = 7;
  localparam int unsigned CUR_W   = 7;
  localparam int unsigned ENTRY_W = 22;
  localparam int unsigned TIME_W  = 22;

  localparam logic [7:0] BYTE_QF    = 8'hF1;
  localparam logic [7:0] BYTE_SOX   = 8'hF0;
  localparam logic [7:0] BYTE_RT    = 8'h7F;
  localparam logic [7:0] BYTE_ID    = 8'h7F;
  localparam logic [7:0] BYTE_MTC   = 8'h01;
  localparam logic [7:0] BYTE_FULL  = 8'h01;
  localparam logic [7:0] RATE_30    = 8'h60;
  localparam logic [7:0] BYTE_EOX   = 8'hF7;
  localparam logic [3:0] HOUR_HI_QF = 4'h6;

  localparam logic [4:0] FRAME_LAST  = 5'd29;
  localparam logic [5:0] SECOND_LAST = 6'd59;
  localparam logic [5:0] MINUTE_LAST = 6'd59;
  localparam logic [4:0] HOUR_LAST   = 5'd23;

  localparam logic [3:0] FF_LAST_IDX = 4'd9;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_GOTO  = 3'd2,
    OP_NEXT  = 3'd3,
    OP_PREV  = 3'd4,
    OP_START = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_IDX,
    CUR_INC,
    CUR_PREV,
    CUR_ZERO
  } cur_sel_t;

  typedef struct packed {
    logic       tick_adv;
    logic       mem_wr;
    cur_sel_t   cur_sel;
    logic       jump_load;
    logic       jump_zero;
    logic       conv_en;
    logic       conv_mem;
    logic [1:0] conv_step;
    logic       save_now;
    logic       emit;
    logic       emit_ff;
    logic [3:0] byte_idx;
    logic       piece_inc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic nonempty;
    logic goto_ok;
    logic more;
    logic le;
  } dp_status_t;

endpackage

FILE: rtl/mtc_ctrl.sv
module mtc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  mtc_pkg::op_t           op,
  input  mtc_pkg::dp_status_t    status,
  output mtc_pkg::ctrl_cmd_t     cmd,
  output logic                   busy
);
  import mtc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_NOW   = 9'b000000010,
    S_CHK   = 9'b000000100,
    S_CONV  = 9'b000001000,
    S_CMP   = 9'b000010000,
    S_QF    = 9'b000100000,
    S_JRD   = 9'b001000000,
    S_JLOAD = 9'b010000000,
    S_FF    = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [3:0] count, count_next;
  logic       zero_entry, zero_entry_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      zero_entry <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      zero_entry <= zero_entry_next;
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.cur_sel     = CUR_HOLD;
    cmd.byte_idx    = count;
    cmd.conv_step   = count[1:0];
    state_next      = state;
    count_next      = count;
    zero_entry_next = zero_entry;
    case (state)
      S_IDLE: begin
        count_next = '0;
        if (start) begin
          case (op)
            OP_TICK: begin
              cmd.tick_adv = 1'b1;
              state_next   = S_NOW;
            end
            OP_LOAD: cmd.mem_wr = 1'b1;
            OP_GOTO: begin
              if (status.goto_ok) begin
                cmd.cur_sel     = CUR_IDX;
                zero_entry_next = 1'b0;
                state_next      = S_JRD;
              end
            end
            OP_NEXT: begin
              if (status.more) begin
                cmd.cur_sel     = CUR_INC;
                zero_entry_next = 1'b0;
                state_next      = S_JRD;
              end
            end
            OP_PREV: begin
              if (status.nonempty) begin
                cmd.cur_sel     = CUR_PREV;
                zero_entry_next = 1'b0;
                state_next      = S_JRD;
              end
            end
            OP_START: begin
              cmd.cur_sel     = CUR_ZERO;
              zero_entry_next = 1'b1;
              state_next      = S_JRD;
            end
            default: ;
          endcase
        end
      end
      S_NOW: begin
        cmd.conv_en = 1'b1;
        if (count == 4'd2) begin
          cmd.save_now = 1'b1;
          count_next   = '0;
          state_next   = S_CHK;
        end else begin
          count_next = count + 4'd1;
        end
      end
      S_CHK: begin
        count_next = '0;
        state_next = status.more ? S_CONV : S_QF;
      end
      S_CONV: begin
        cmd.conv_en  = 1'b1;
        cmd.conv_mem = 1'b1;
        if (count == 4'd2) begin
          count_next = '0;
          state_next = S_CMP;
        end else begin
          count_next = count + 4'd1;
        end
      end
      S_CMP: begin
        count_next = '0;
        if (status.le) begin
          cmd.cur_sel = CUR_INC;
          state_next  = S_CHK;
        end else begin
          state_next = S_QF;
        end
      end
      S_QF: begin
        cmd.emit = 1'b1;
        if (count == 4'd1) begin
          cmd.piece_inc = 1'b1;
          count_next    = '0;
          state_next    = S_IDLE;
        end else begin
          count_next = count + 4'd1;
        end
      end
      S_JRD: begin
        count_next = '0;
        state_next = S_JLOAD;
      end
      S_JLOAD: begin
        cmd.jump_load = 1'b1;
        cmd.jump_zero = zero_entry;
        count_next    = '0;
        state_next    = S_FF;
      end
      S_FF: begin
        cmd.emit    = 1'b1;
        cmd.emit_ff = 1'b1;
        if (count == FF_LAST_IDX) begin
          count_next = '0;
          state_next = S_IDLE;
        end else begin
          count_next = count + 4'd1;
        end
      end
      default: begin
        count_next = '0;
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/mtc_dp.sv
module mtc_dp #(
  parameter int unsigned MAX_MARKERS = mtc_pkg::MAX_MARKERS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mtc_pkg::ctrl_cmd_t     cmd,
  output mtc_pkg::dp_status_t    status,
  input  logic [5:0]             marker_index,
  input  logic [4:0]             hours,
  input  logic [5:0]             minutes,
  input  logic [5:0]             seconds,
  input  logic [4:0]             frames,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [6:0]             cfg_data,
  output logic                   result_valid,
  output logic [7:0]             out_byte,
  output logic                   last_byte,
  output logic [5:0]             cursor
);
  import mtc_pkg::*;

  localparam int unsigned AW  = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
  localparam int unsigned CAP = (MAX_MARKERS < 128) ? MAX_MARKERS : 127;

  logic [CNT_W-1:0]   marker_count;
  logic [CNT_W-1:0]   eff;
  logic [CUR_W-1:0]   cur, cur_next, prev_c;
  logic [4:0]         hc, hc_next;
  logic [5:0]         mc, mc_next;
  logic [5:0]         sc, sc_next;
  logic [4:0]         fc, fc_next;
  logic [1:0]         sub, sub_next;
  logic               after_jump, after_jump_next;
  logic [2:0]         piece;
  logic [ENTRY_W-1:0] mem [MAX_MARKERS];
  logic [ENTRY_W-1:0] rdata;
  logic [AW+6-1:0]    wa_wide;
  logic [AW+7-1:0]    ra_wide;
  logic [TIME_W-1:0]  acc, acc_next, now;
  logic [4:0]         sh, sf;
  logic [5:0]         sm, ss;
  logic [3:0]         nib;
  logic [7:0]         byte_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      marker_count <= cfg_data;
    end
  end

  assign eff = (marker_count > CNT_W'(CAP)) ? CNT_W'(CAP) : marker_count;

  assign status.nonempty = (eff != '0);
  assign status.goto_ok  = ({1'b0, marker_index} < eff);
  assign status.more     = ((cur + 7'd1) < eff);
  assign status.le       = (acc <= now);

  // marker store
  assign wa_wide = (AW + 6)'(marker_index);
  assign ra_wide = (AW + 7)'(cur);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && (32'(marker_index) < 32'(MAX_MARKERS))) begin
      mem[wa_wide[AW-1:0]] <= {hours, minutes, seconds, frames};
    end
    rdata <= mem[ra_wide[AW-1:0]];
  end

  // cursor
  always_comb begin
    prev_c = (cur > 7'd1) ? cur - 7'd2 : '0;
    if (prev_c >= eff) begin
      prev_c = eff - 7'd1;
    end
    case (cmd.cur_sel)
      CUR_IDX:  cur_next = {1'b0, marker_index};
      CUR_INC:  cur_next = cur + 7'd1;
      CUR_PREV: cur_next = prev_c;
      CUR_ZERO: cur_next = '0;
      default:  cur_next = cur;
    endcase
  end

  // timecode
  always_comb begin
    hc_next         = hc;
    mc_next         = mc;
    sc_next         = sc;
    fc_next         = fc;
    sub_next        = sub;
    after_jump_next = after_jump;
    if (cmd.jump_load) begin
      if (cmd.jump_zero) begin
        {hc_next, mc_next, sc_next, fc_next} = '0;
      end else begin
        {hc_next, mc_next, sc_next, fc_next} = rdata;
      end
      sub_next        = '0;
      after_jump_next = 1'b1;
    end else if (cmd.tick_adv) begin
      if (after_jump) begin
        after_jump_next = 1'b0;
        sub_next        = '0;
      end else if (sub == 2'd3) begin
        sub_next = '0;
        if (fc < FRAME_LAST) begin
          fc_next = fc + 5'd1;
        end else begin
          fc_next = '0;
          if (sc < SECOND_LAST) begin
            sc_next = sc + 6'd1;
          end else begin
            sc_next = '0;
            if (mc < MINUTE_LAST) begin
              mc_next = mc + 6'd1;
            end else begin
              mc_next = '0;
              hc_next = (hc < HOUR_LAST) ? hc + 5'd1 : '0;
            end
          end
        end
      end else begin
        sub_next = sub + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hc         <= '0;
      mc         <= '0;
      sc         <= '0;
      fc         <= '0;
      sub        <= '0;
      after_jump <= 1'b1;
      piece      <= '0;
      cur        <= '0;
    end else begin
      hc         <= hc_next;
      mc         <= mc_next;
      sc         <= sc_next;
      fc         <= fc_next;
      sub        <= sub_next;
      after_jump <= after_jump_next;
      cur        <= cur_next;
      if (cmd.jump_load) begin
        piece <= '0;
      end else if (cmd.piece_inc) begin
        piece <= piece + 3'd1;
      end
    end
  end

  // frame count: ((h*60 + m)*60 + s)*30 + f, one step a cycle
  always_comb begin
    if (cmd.conv_mem) begin
      {sh, sm, ss, sf} = rdata;
    end else begin
      {sh, sm, ss, sf} = {hc, mc, sc, fc};
    end
    case (cmd.conv_step)
      2'd0:    acc_next = (TIME_W'(sh) << 6) - (TIME_W'(sh) << 2) + TIME_W'(sm);
      2'd1:    acc_next = (acc << 6) - (acc << 2) + TIME_W'(ss);
      default: acc_next = (acc << 5) - (acc << 1) + TIME_W'(sf);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_en) begin
      acc <= acc_next;
    end
    if (cmd.save_now) begin
      now <= acc_next;
    end
  end

  // output byte
  always_comb begin
    case (piece)
      3'd0:    nib = fc[3:0];
      3'd1:    nib = {3'b000, fc[4]};
      3'd2:    nib = sc[3:0];
      3'd3:    nib = {2'b00, sc[5:4]};
      3'd4:    nib = mc[3:0];
      3'd5:    nib = {2'b00, mc[5:4]};
      3'd6:    nib = hc[3:0];
      default: nib = HOUR_HI_QF | {3'b000, hc[4]};
    endcase
    if (cmd.emit_ff) begin
      case (cmd.byte_idx)
        4'd0:    byte_next = BYTE_SOX;
        4'd1:    byte_next = BYTE_RT;
        4'd2:    byte_next = BYTE_ID;
        4'd3:    byte_next = BYTE_MTC;
        4'd4:    byte_next = BYTE_FULL;
        4'd5:    byte_next = RATE_30 | {3'b000, hc};
        4'd6:    byte_next = {2'b00, mc};
        4'd7:    byte_next = {2'b00, sc};
        4'd8:    byte_next = {3'b000, fc};
        default: byte_next = BYTE_EOX;
      endcase
    end else begin
      byte_next = (cmd.byte_idx[0]) ? {1'b0, piece, nib} : BYTE_QF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      out_byte  <= byte_next;
      last_byte <= cmd.emit_ff ? (cmd.byte_idx == FF_LAST_IDX) : cmd.byte_idx[0];
      cursor    <= cur[5:0];
    end
  end

endmodule

FILE: rtl/midi_timecode_generator_unit.sv
// MIDI time code generator. Pulse start with op and its fields while busy is
// low. A tick advances the time and converts it with the frame-count unit; each
// marker the cursor is compared against then adds three shift-add steps of that
// unit and the compare, and each marker it moves past adds the next table read.
// It then sends F1 and the quarter-frame byte. Goto, next, prev and start, when
// the move is allowed, send the ten-byte full-frame SysEx; load writes an entry.
// Bytes leave on out_byte one per cycle, each valid for exactly one cycle while
// result_valid is high; they cannot be held off, so the receiver must take every
// byte as it comes. The marker table holds garbage until each entry is loaded.
module midi_timecode_generator_unit #(
  parameter int unsigned MAX_MARKERS = mtc_pkg::MAX_MARKERS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op,
  input  logic [5:0] marker_index,
  input  logic [4:0] hours,
  input  logic [5:0] minutes,
  input  logic [5:0] seconds,
  input  logic [4:0] frames,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output logic       result_valid,
  output logic [7:0] out_byte,
  output logic       last_byte,
  output logic [5:0] cursor
);
  import mtc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mtc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op_t'(op)),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mtc_dp #(
    .MAX_MARKERS (MAX_MARKERS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .marker_index (marker_index),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .frames       (frames),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .out_byte     (out_byte),
    .last_byte    (last_byte),
    .cursor       (cursor)
  );

endmodule
